// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the temporal max pooling block.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tmpa_pkg.sv -----
// Package of the temporal max pooling block: widths, register indexes,
// default parameters and the types passed between its modules. No dependencies.
package tmpa_pkg;

  localparam int DEF_MAX_KERNEL   = 16;
  localparam int DEF_MAX_FEATURES = 256;
  localparam int DEF_MAX_FRAMES   = 65536;

  localparam int SAMPLE_BITS    = 16;
  localparam int OFFSET_BITS    = 4;
  localparam int OUT_FRAME_BITS = 16;
  localparam int FEATURE_BITS   = 8;
  localparam int OUT_DATA_BITS  = 48;

  localparam int KW_BITS       = 5;
  localparam int DW_BITS       = 5;
  localparam int FS_BITS       = 9;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 9;

  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_WIDTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE       = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_SIZE   = 2'd2;

  localparam logic [KW_BITS-1:0] RST_KERNEL_WIDTH = 5'd2;
  localparam logic [DW_BITS-1:0] RST_STRIDE       = 5'd2;
  localparam logic [FS_BITS-1:0] RST_FRAME_SIZE   = 9'd1;

  // Effective settings, already clamped into their legal ranges.
  typedef struct packed {
    logic [KW_BITS-1:0] kw;
    logic [DW_BITS-1:0] dw;
    logic [FS_BITS-1:0] fs;
  } tmpa_cfg_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic skip;
    logic upd;
    logic adv_init;
    logic adv_step;
    logic fin;
  } tmpa_cmd_t;

  typedef struct packed {
    logic in_range;
    logic scan_more;
    logic win_open;
    logic closing;
    logic emit_busy;
    logic frame_end;
    logic adv_more;
  } tmpa_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_ADV,
    ST_FIN
  } tmpa_state_t;

endpackage

// ----- rtl/tmpa_cfg.sv -----
// Configuration registers of the temporal max pooling block and their clamping.
// Depends on tmpa_pkg.
module tmpa_cfg #(
  parameter int MAX_KERNEL   = tmpa_pkg::DEF_MAX_KERNEL,
  parameter int MAX_FEATURES = tmpa_pkg::DEF_MAX_FEATURES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tmpa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tmpa_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output tmpa_pkg::tmpa_cfg_t                cfg_eff
);
  import tmpa_pkg::*;

  logic [KW_BITS-1:0] kernel_width_r;
  logic [DW_BITS-1:0] stride_r;
  logic [FS_BITS-1:0] frame_size_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_width_r <= RST_KERNEL_WIDTH;
      stride_r       <= RST_STRIDE;
      frame_size_r   <= RST_FRAME_SIZE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KERNEL_WIDTH: kernel_width_r <= cfg_data[KW_BITS-1:0];
        REG_STRIDE:       stride_r       <= cfg_data[DW_BITS-1:0];
        REG_FRAME_SIZE:   frame_size_r   <= cfg_data[FS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Zero means one; values above the build limits are held at the limit.
  always_comb begin
    if (kernel_width_r == '0) begin
      cfg_eff.kw = KW_BITS'(1);
    end else if (32'(kernel_width_r) > MAX_KERNEL) begin
      cfg_eff.kw = KW_BITS'(MAX_KERNEL);
    end else begin
      cfg_eff.kw = kernel_width_r;
    end
    cfg_eff.dw = (stride_r == '0) ? DW_BITS'(1) : stride_r;
    if (frame_size_r == '0) begin
      cfg_eff.fs = FS_BITS'(1);
    end else if (32'(frame_size_r) > MAX_FEATURES) begin
      cfg_eff.fs = FS_BITS'(MAX_FEATURES);
    end else begin
      cfg_eff.fs = frame_size_r;
    end
  end

endmodule

// ----- rtl/tmpa_ctrl.sv -----
// Controller state machine of the temporal max pooling block.
// Depends on tmpa_pkg; drives the datapath through tmpa_cmd_t.
module tmpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  tmpa_pkg::tmpa_sts_t sts,
  output tmpa_pkg::tmpa_cmd_t cmd
);
  import tmpa_pkg::*;

  tmpa_state_t state_r;
  tmpa_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.in_range && sts.scan_more) begin
          if (sts.win_open) begin
            cmd.rd    = 1'b1;
            state_nxt = ST_UPD;
          end else begin
            cmd.skip = 1'b1;
          end
        end else if (sts.in_range && sts.frame_end) begin
          cmd.adv_init = 1'b1;
          state_nxt    = ST_ADV;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_UPD: begin
        if (!sts.emit_busy) begin
          cmd.upd   = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_ADV: begin
        if (sts.adv_more) begin
          cmd.adv_step = 1'b1;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/tmpa_dp.sv -----
// Datapath of the temporal max pooling block: counters, window store and
// result register. Depends on tmpa_pkg; steered by tmpa_ctrl.
module tmpa_dp #(
  parameter int MAX_KERNEL   = tmpa_pkg::DEF_MAX_KERNEL,
  parameter int MAX_FEATURES = tmpa_pkg::DEF_MAX_FEATURES,
  parameter int MAX_FRAMES   = tmpa_pkg::DEF_MAX_FRAMES
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  tmpa_pkg::tmpa_cfg_t                        cfg_eff,
  input  tmpa_pkg::tmpa_cmd_t                        cmd,
  output tmpa_pkg::tmpa_sts_t                        sts,
  input  logic signed [tmpa_pkg::SAMPLE_BITS-1:0]    in_sample,
  input  logic                                       in_eos,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic signed [tmpa_pkg::SAMPLE_BITS-1:0]    out_max_value,
  output logic [tmpa_pkg::OFFSET_BITS-1:0]           out_max_offset,
  output logic [tmpa_pkg::OUT_FRAME_BITS-1:0]        out_frame_idx,
  output logic [tmpa_pkg::FEATURE_BITS-1:0]          out_feature,
  output logic                                       out_frame_done
);
  import tmpa_pkg::*;

  localparam int SLOT_BITS  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int KCNT_BITS  = $clog2(MAX_KERNEL + 1);
  localparam int FEAT_BITS  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int FCNT_BITS  = $clog2(MAX_FRAMES + 1);
  localparam int S_BITS     = FCNT_BITS + DW_BITS;
  localparam int DEPTH      = MAX_KERNEL * MAX_FEATURES;
  localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENTRY_BITS = SAMPLE_BITS + SLOT_BITS;

  // Sequence state.
  logic [FEAT_BITS-1:0] feat_r;
  logic [FCNT_BITS-1:0] frame_r;
  logic [FCNT_BITS-1:0] oow_r;
  logic [SLOT_BITS-1:0] oslot_r;

  // Item in work.
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          eos_r;
  logic [FEAT_BITS-1:0]          y_r;
  logic [FCNT_BITS-1:0]          f_r;
  logic [FCNT_BITS-1:0]          w_r;
  logic [SLOT_BITS-1:0]          slot_r;
  logic [S_BITS-1:0]             s_r;
  logic [S_BITS-1:0]             p_r;
  logic [KCNT_BITS-1:0]          k_r;
  logic [SLOT_BITS-1:0]          off_r;
  logic signed [SAMPLE_BITS-1:0] rd_max_r;
  logic [SLOT_BITS-1:0]          rd_arg_r;

  logic [ENTRY_BITS-1:0] store_mem [DEPTH];

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_max_value_r;
  logic [OFFSET_BITS-1:0]        out_max_offset_r;
  logic [OUT_FRAME_BITS-1:0]     out_frame_idx_r;
  logic [FEATURE_BITS-1:0]       out_feature_r;
  logic                          out_frame_done_r;

  logic [FEAT_BITS-1:0]          y_clamp;
  logic [S_BITS-1:0]             prod;
  logic [S_BITS-1:0]             dw_ext;
  logic [S_BITS-1:0]             f_ext;
  logic [S_BITS-1:0]             off_full;
  logic [SLOT_BITS-1:0]          slot_inc;
  logic [SLOT_BITS-1:0]          oslot_inc;
  logic [ADDR_BITS-1:0]          addr;
  logic                          take;
  logic signed [SAMPLE_BITS-1:0] new_max;
  logic [SLOT_BITS-1:0]          new_arg;
  logic                          is_last_feat;

  always_comb begin
    // A feature count left over from a larger frame size is held at the last feature.
    y_clamp   = (32'(feat_r) >= 32'(cfg_eff.fs)) ? FEAT_BITS'(32'(cfg_eff.fs) - 1) : feat_r;
    dw_ext    = S_BITS'(cfg_eff.dw);
    prod      = S_BITS'(oow_r) * dw_ext;
    f_ext     = S_BITS'(f_r);
    off_full  = f_ext - s_r;
    slot_inc  = (32'(slot_r) == MAX_KERNEL - 1) ? '0 : slot_r + 1'b1;
    oslot_inc = (32'(oslot_r) == MAX_KERNEL - 1) ? '0 : oslot_r + 1'b1;
    addr      = ADDR_BITS'(32'(slot_r) * MAX_FEATURES + 32'(y_r));
    take      = (off_r == '0) || (sample_r > rd_max_r);
    new_max   = take ? sample_r : rd_max_r;
    new_arg   = take ? off_r : rd_arg_r;
    is_last_feat = (32'(y_r) == 32'(cfg_eff.fs) - 1);

    sts.in_range  = (32'(f_r) < MAX_FRAMES);
    sts.scan_more = (k_r < KCNT_BITS'(MAX_KERNEL)) && (s_r <= f_ext);
    sts.win_open  = (off_full < S_BITS'(cfg_eff.kw));
    sts.closing   = (32'(off_r) == 32'(cfg_eff.kw) - 1);
    sts.emit_busy = sts.closing && out_valid_r && !out_ready;
    sts.frame_end = (32'(y_r) + 1 >= 32'(cfg_eff.fs));
    sts.adv_more  = (k_r < KCNT_BITS'(MAX_KERNEL)) &&
                    (p_r + S_BITS'(cfg_eff.kw) - S_BITS'(1) <= f_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feat_r      <= '0;
      frame_r     <= '0;
      oow_r       <= '0;
      oslot_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.upd && sts.closing) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.adv_step) begin
        oow_r   <= oow_r + 1'b1;
        oslot_r <= oslot_inc;
      end
      if (cmd.fin) begin
        if (eos_r) begin
          feat_r  <= '0;
          frame_r <= '0;
          oow_r   <= '0;
          oslot_r <= '0;
        end else if (sts.frame_end) begin
          feat_r <= '0;
          if (sts.in_range) begin
            frame_r <= f_r + 1'b1;
          end
        end else begin
          feat_r <= y_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
      eos_r    <= in_eos;
      y_r      <= y_clamp;
      f_r      <= frame_r;
      w_r      <= oow_r;
      slot_r   <= oslot_r;
      s_r      <= prod;
      p_r      <= prod;
      k_r      <= '0;
    end
    if (cmd.rd) begin
      off_r <= off_full[SLOT_BITS-1:0];
    end
    if (cmd.skip || cmd.upd) begin
      w_r    <= w_r + 1'b1;
      slot_r <= slot_inc;
      s_r    <= s_r + dw_ext;
      k_r    <= k_r + 1'b1;
    end
    if (cmd.adv_init) begin
      k_r <= '0;
    end
    if (cmd.adv_step) begin
      p_r <= p_r + dw_ext;
      k_r <= k_r + 1'b1;
    end
    if (cmd.upd && sts.closing) begin
      out_max_value_r  <= new_max;
      out_max_offset_r <= OFFSET_BITS'(new_arg);
      out_frame_idx_r  <= OUT_FRAME_BITS'(w_r);
      out_feature_r    <= FEATURE_BITS'(y_r);
      out_frame_done_r <= is_last_feat;
    end
  end

  // Single-port window store: read in the scan step, written back in the update step.
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      store_mem[addr] <= {new_arg, new_max};
    end
    if (cmd.rd) begin
      {rd_arg_r, rd_max_r} <= store_mem[addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_max_value  = out_max_value_r;
  assign out_max_offset = out_max_offset_r;
  assign out_frame_idx  = out_frame_idx_r;
  assign out_feature    = out_feature_r;
  assign out_frame_done = out_frame_done_r;

endmodule

// ----- rtl/temporal_max_pool_argmax.sv -----
// Temporal max pooling with argmax: one sample is taken at a time and each
// open window that it falls in is updated in the window store. A sample is
// accepted only in the idle state; the controller then scans the windows from
// the oldest open one (at most MAX_KERNEL of them), skipping those that do not
// contain the sample and reading and writing back each one that does (about
// kernel_width/stride of them, rounded up). After the last feature of a frame
// it also advances past the windows that close with it; each sample ends in idle.
// The single-port window store gives each open window a read step and a
// write-back step. A finished result waits in an output register, so the next
// word is taken while the result is still unclaimed; only a second result
// stalls behind it. The window store is not cleared after reset, and
// configuration must only be written while the block is idle.
`include "assert_macros.svh"

module temporal_max_pool_argmax #(
  parameter int MAX_KERNEL   = tmpa_pkg::DEF_MAX_KERNEL,
  parameter int MAX_FEATURES = tmpa_pkg::DEF_MAX_FEATURES,
  parameter int MAX_FRAMES   = tmpa_pkg::DEF_MAX_FRAMES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tmpa_pkg::SAMPLE_BITS-1:0]   in_tdata,  // [15:0] sample
  input  logic                               in_tlast,  // end of sequence
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] max_value, [19:16] max_offset, [35:20] out_frame, [43:36] feature,
  // [47:44] zero
  output logic [tmpa_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic                               out_tlast, // frame_done
  // Configuration writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tmpa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tmpa_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import tmpa_pkg::*;

  tmpa_cfg_t cfg_eff;
  tmpa_cmd_t cmd;
  tmpa_sts_t sts;

  logic signed [SAMPLE_BITS-1:0] max_value;
  logic [OFFSET_BITS-1:0]        max_offset;
  logic [OUT_FRAME_BITS-1:0]     out_frame;
  logic [FEATURE_BITS-1:0]       feature;

  tmpa_cfg #(
    .MAX_KERNEL  (MAX_KERNEL),
    .MAX_FEATURES(MAX_FEATURES)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg_eff  (cfg_eff)
  );

  tmpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmpa_dp #(
    .MAX_KERNEL  (MAX_KERNEL),
    .MAX_FEATURES(MAX_FEATURES),
    .MAX_FRAMES  (MAX_FRAMES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_eff       (cfg_eff),
    .cmd           (cmd),
    .sts           (sts),
    .in_sample     (in_tdata),
    .in_eos        (in_tlast),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_max_value (max_value),
    .out_max_offset(max_offset),
    .out_frame_idx (out_frame),
    .out_feature   (feature),
    .out_frame_done(out_tlast)
  );

  // The result word is packed from the lowest field up, padded to whole bytes.
  assign out_tdata = {4'b0000, feature, out_frame, max_offset, max_value};

  // A word is taken only from the idle state, so the next cycle never accepts.
  `ASSERT_NXT(a_one_item_at_a_time, in_tvalid && in_tready, !in_tready, "second word accepted while busy")
  // The controller issues at most one datapath command per cycle.
  `ASSERT_IMP(a_cmd_exclusive, 1'b1, $onehot0(cmd), "more than one datapath command at once")
  // The datapath only loads a word on a completed input handshake.
  `ASSERT_IMP(a_load_on_handshake, cmd.load, in_tvalid && in_tready, "load without handshake")
  // A closing window update always leaves a result in the output register.
  `ASSERT_NXT(a_result_registered, cmd.upd && sts.closing, out_tvalid, "closed window gave no result")

endmodule

// ----- tb/tmpa_checker.sv -----
// Checker of the temporal max pooling block: watches the input, result and
// configuration channels, predicts each result word and compares it.
// Depends on tmpa_pkg for widths, register indexes and reset settings.
module tmpa_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [tmpa_pkg::SAMPLE_BITS-1:0]   in_tdata,
  input  logic                               in_tlast,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [tmpa_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input  logic                               out_tlast,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [tmpa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tmpa_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                 fails,
  output int                                 pending
);
  import tmpa_pkg::*;

  localparam int MAX_KERNEL   = DEF_MAX_KERNEL;
  localparam int MAX_FEATURES = DEF_MAX_FEATURES;
  localparam int MAX_FRAMES   = DEF_MAX_FRAMES;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic [OFFSET_BITS-1:0]        max_offset;
    logic [OUT_FRAME_BITS-1:0]     out_frame;
    logic [FEATURE_BITS-1:0]       feature;
    logic                          frame_done;
  } pool_result_t;

  // Running maximum and its offset, per (window slot, feature).
  logic signed [SAMPLE_BITS-1:0] win_max [MAX_KERNEL*MAX_FEATURES];
  logic [OFFSET_BITS-1:0]        win_arg [MAX_KERNEL*MAX_FEATURES];

  int unsigned feat_idx;
  int unsigned frame_idx;
  int unsigned oldest_win;

  logic [KW_BITS-1:0] kernel_reg;
  logic [DW_BITS-1:0] stride_reg;
  logic [FS_BITS-1:0] fsize_reg;

  pool_result_t pooled_q [$];
  int           fail_count;

  task automatic report_mismatch(input string what, input longint got_v,
                                 input longint want_v);
    fail_count++;
    $display("%0t mismatch in %s: got %0d, wanted %0d", $time, what, got_v, want_v);
  endtask

  // Folds one sample into every open window that contains it.
  task automatic pool_sample(input logic signed [SAMPLE_BITS-1:0] val,
                             input logic seq_end);
    int unsigned  kw, dw, fs, f, y, w, s, off, addr;
    bit           got;
    pool_result_t r;
    kw  = (kernel_reg == 0) ? 1 :
          (32'(kernel_reg) > MAX_KERNEL) ? MAX_KERNEL : 32'(kernel_reg);
    dw  = (stride_reg == 0) ? 1 : 32'(stride_reg);
    fs  = (fsize_reg == 0) ? 1 :
          (32'(fsize_reg) > MAX_FEATURES) ? MAX_FEATURES : 32'(fsize_reg);
    f   = frame_idx;
    y   = (feat_idx >= fs) ? fs - 1 : feat_idx;
    got = 1'b0;
    r   = '0;
    if (f < MAX_FRAMES) begin
      for (int k = 0; k < MAX_KERNEL; k++) begin
        w = oldest_win + k;
        s = w * dw;
        if (s > f) break;
        off = f - s;
        if (off >= kw) continue;
        addr = (w % MAX_KERNEL) * MAX_FEATURES + y;
        // Ties keep the earlier offset.
        if (off == 0 || val > win_max[addr]) begin
          win_max[addr] = val;
          win_arg[addr] = off[OFFSET_BITS-1:0];
        end
        if (off == kw - 1 && !got) begin
          r.max_value  = win_max[addr];
          r.max_offset = win_arg[addr];
          r.out_frame  = w[OUT_FRAME_BITS-1:0];
          r.feature    = y[FEATURE_BITS-1:0];
          r.frame_done = (y == fs - 1);
          got = 1'b1;
        end
      end
    end
    if (y + 1 >= fs) begin
      feat_idx = 0;
      if (f < MAX_FRAMES) begin
        for (int k = 0; k < MAX_KERNEL; k++) begin
          if (oldest_win * dw + kw - 1 <= f)
            oldest_win++;
          else
            break;
        end
        frame_idx = f + 1;
      end
    end else begin
      feat_idx = y + 1;
    end
    if (seq_end) begin
      feat_idx   = 0;
      frame_idx  = 0;
      oldest_win = 0;
    end
    if (got) pooled_q.push_back(r);
  endtask

  task automatic check_result();
    pool_result_t want;
    if (pooled_q.size() == 0) begin
      report_mismatch("unexpected result word", longint'(out_tdata), 0);
    end else begin
      want = pooled_q.pop_front();
      if ($signed(out_tdata[15:0]) !== want.max_value)
        report_mismatch("max_value", longint'($signed(out_tdata[15:0])),
                        longint'(want.max_value));
      if (out_tdata[19:16] !== want.max_offset)
        report_mismatch("max_offset", longint'(out_tdata[19:16]),
                        longint'(want.max_offset));
      if (out_tdata[35:20] !== want.out_frame)
        report_mismatch("out_frame", longint'(out_tdata[35:20]),
                        longint'(want.out_frame));
      if (out_tdata[43:36] !== want.feature)
        report_mismatch("feature", longint'(out_tdata[43:36]),
                        longint'(want.feature));
      if (out_tdata[47:44] !== 4'd0)
        report_mismatch("padding", longint'(out_tdata[47:44]), 0);
      if (out_tlast !== want.frame_done)
        report_mismatch("frame_done", longint'(out_tlast), longint'(want.frame_done));
    end
  endtask

  // The window store is left alone at reset; it is undefined in the block too.
  always @(posedge clk) begin
    if (!rst_n) begin
      feat_idx   = 0;
      frame_idx  = 0;
      oldest_win = 0;
      kernel_reg = RST_KERNEL_WIDTH;
      stride_reg = RST_STRIDE;
      fsize_reg  = RST_FRAME_SIZE;
      fail_count = 0;
      pooled_q.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KERNEL_WIDTH: kernel_reg = cfg_data[KW_BITS-1:0];
          REG_STRIDE:       stride_reg = cfg_data[DW_BITS-1:0];
          REG_FRAME_SIZE:   fsize_reg  = cfg_data[FS_BITS-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) pool_sample(in_tdata, in_tlast);
    end
    fails   <= fail_count;
    pending <= pooled_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the temporal max pooling testbench: clock, reset, stimulus, idling
// on both streams, a watchdog and the verdict. Needs tmpa_pkg, the block
// temporal_max_pool_argmax and the checker module tmpa_checker.
module tb_top;
  import tmpa_pkg::*;

  // Longest stretch with no handshake on any channel before the run is abandoned.
  // A slow word scans and writes back every window and then advances past the
  // closed ones; with sender gaps and receiver stalls this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles allowed after the last expected result for a word that closes no
  // window to finish its write-back.
  localparam int SETTLE_CYCLES  = 64;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [SAMPLE_BITS-1:0]   in_tdata   = '0;
  logic                     in_tlast   = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tlast;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index  = REG_KERNEL_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data   = '0;

  int fails;
  int pending;
  int idle_cycles = 0;

  // Idling controls shared by the sender and the receiver.
  bit idling  = 1'b1;
  int gap_pct = 25;

  // Effective settings, needed to shape well-formed sequences.
  int cur_kw = int'(RST_KERNEL_WIDTH);
  int cur_dw = int'(RST_STRIDE);
  int cur_fs = int'(RST_FRAME_SIZE);

  temporal_max_pool_argmax uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tmpa_checker pool_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fails      (fails),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Sends one word and returns at the edge where it is taken. The valid is
  // only lowered for a gap, so back-to-back words keep it high throughout.
  task automatic send_word(input logic [SAMPLE_BITS-1:0] value, input logic seq_end);
    if (idling && $urandom_range(1, 100) <= gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= seq_end;
    do @(posedge clk); while (!in_tready);
  endtask

  // Waits until the block has drained: every expected result has arrived and
  // any word that closed no window has had time to be written back.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back with the valid held high.
  task automatic set_config(input int kw, input int dw, input int fs);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_KERNEL_WIDTH;
    cfg_data  <= CFG_DATA_BITS'(kw);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_STRIDE;
    cfg_data  <= CFG_DATA_BITS'(dw);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_FRAME_SIZE;
    cfg_data  <= CFG_DATA_BITS'(fs);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_kw = (kw == 0) ? 1 : (kw > DEF_MAX_KERNEL) ? DEF_MAX_KERNEL : kw;
    cur_dw = (dw == 0) ? 1 : dw;
    cur_fs = (fs == 0) ? 1 : (fs > DEF_MAX_FEATURES) ? DEF_MAX_FEATURES : fs;
  endtask

  // Sample values lean towards the extremes and a narrow band around zero,
  // so that ties within a window are common.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2, 3:    return 16'($signed($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  // A sequence of whole frames plus an optional partial frame; the last word
  // always carries end of sequence, so the counters are back at zero afterwards.
  task automatic run_sequence(input int frames, input int tail);
    int total;
    total = frames * cur_fs + tail;
    for (int i = 0; i < total; i++)
      send_word(pick_sample(), i == total - 1);
  endtask

  // Mostly well-formed sequences that end exactly where a window closes; the
  // rest stop short of a window end or part way through a frame.
  task automatic random_phase(input int kw, input int dw, input int fs, input int budget);
    int sent, frames, tail, k;
    set_config(kw, dw, fs);
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 4) != 0) begin
        k      = $urandom_range(0, 3);
        frames = cur_kw + cur_dw * k;
        while (k > 0 && frames * cur_fs > 160) begin
          k--;
          frames = cur_kw + cur_dw * k;
        end
        tail = 0;
      end else begin
        frames = $urandom_range(0, cur_kw + cur_dw);
        if (frames * cur_fs > 160) frames = 160 / cur_fs;
        tail = $urandom_range(1, cur_fs);
      end
      run_sequence(frames, tail);
      sent += frames * cur_fs + tail;
    end
  endtask

  // Result side: stall bursts between stretches of readiness.
  initial begin
    forever begin
      if (idling && $urandom_range(1, 100) <= gap_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Watchdog: any handshake restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[temporal_max_pool_argmax] ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [SAMPLE_BITS-1:0] overlap_seq [9];
    overlap_seq = '{16'd100, 16'hfffb, 16'd100, 16'h7fff, 16'h8000, 16'h7fff,
                    16'd200, 16'd0, 16'd1};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings (kernel 2, stride 2, one feature): the extremes, a tie
    // that must keep the first offset, and a trailing window left open.
    send_word(16'h8000, 1'b0);
    send_word(16'h7fff, 1'b0);
    send_word(16'd7, 1'b0);
    send_word(16'd7, 1'b0);
    send_word(16'hffff, 1'b1);

    // Zero in every register acts as one.
    set_config(0, 0, 0);
    send_word(16'd1, 1'b0);
    send_word(16'hfffe, 1'b0);
    send_word(16'd3, 1'b1);

    // Overlapping windows over two features, ending in a partial frame.
    set_config(3, 1, 2);
    foreach (overlap_seq[i]) send_word(overlap_seq[i], i == 8);

    // Registers above their range clamp; a sequence shorter than the kernel
    // gives nothing.
    set_config(31, 31, 511);
    send_word(16'h1234, 1'b0);
    send_word(16'hedcb, 1'b1);

    // Random part: the extreme settings first, then a spread of random ones.
    idling  = 1'b1;
    gap_pct = 25;
    random_phase(16, 1, 4, 120);
    random_phase(1, 16, 3, 90);
    random_phase(16, 16, 1, 90);
    random_phase(17, 0, 0, 60);

    // The widest frame, clamped to the largest feature count, kept short.
    set_config(1, 1, 300);
    run_sequence(1, 0);

    // The last phases use random settings; idling on both sides is off in the third, sixth and eighth.
    for (int p = 0; p < 8; p++) begin
      idling  = (p % 3 != 2) && (p != 7);
      gap_pct = 10 + $urandom_range(0, 40);
      random_phase($urandom_range(0, 20), $urandom_range(0, 18), $urandom_range(0, 6), 50);
    end

    settle();
    if (fails == 0 && pending == 0)
      $display("[temporal_max_pool_argmax] OK");
    else
      $display("[temporal_max_pool_argmax] ERROR");
    $finish;
  end

endmodule
